// ===== hdl/aahc_pkg.sv =====
// Shared types, constants and elaboration-time tables for the altitude/azimuth unit.
// Holds the whole-degree sine table and the CORDIC arctangent table, both in Q30.
// No dependencies.
package aahc_pkg;

	localparam int FRAC = 30;
	localparam int QW = 34;
	localparam int QB = 18;
	localparam int SIN_TERMS = 19;
	localparam int ATAN_ROM_SIZE = 48;
	localparam int ATAN_TERMS = 30;

	typedef logic signed [QW-1:0] q_t;
	typedef logic [63:0] u64_t;
	typedef logic [30:0] rom_word_t;
	typedef rom_word_t sin_rom_t [0:90];
	typedef rom_word_t atan_rom_t [0:ATAN_ROM_SIZE-1];
	typedef u64_t sin_div_t [1:SIN_TERMS];
	typedef u64_t atan_div_t [0:ATAN_TERMS-1];

	typedef struct packed {
		q_t t;
		q_t ax;
		q_t ay;
	} side_t;

	localparam u64_t HALF_Q = 64'd1 << (FRAC - 1);
	localparam u64_t PI_Q32 = 64'h3_243F_6A89;
	localparam q_t PI_Q30 = q_t'((PI_Q32 + 64'd2) >> 2);
	localparam q_t ONE_Q = q_t'(64'd1 << FRAC);

	localparam sin_div_t SIN_DIV_ODD = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
		64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056, 64'd1190,
		64'd1332, 64'd1482
	};
	localparam sin_div_t SIN_DIV_EVEN = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306,
		64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992, 64'd1122,
		64'd1260, 64'd1406
	};
	localparam atan_div_t ATAN_DIV = '{
		64'd1, 64'd3, 64'd5, 64'd7, 64'd9, 64'd11, 64'd13, 64'd15, 64'd17, 64'd19,
		64'd21, 64'd23, 64'd25, 64'd27, 64'd29, 64'd31, 64'd33, 64'd35, 64'd37, 64'd39,
		64'd41, 64'd43, 64'd45, 64'd47, 64'd49, 64'd51, 64'd53, 64'd55, 64'd57, 64'd59
	};

	function automatic u64_t series(u64_t x, logic odd);
		u64_t x2;
		u64_t t;
		u64_t s;
		x2 = (x * x + HALF_Q) >> FRAC;
		t = odd ? x : (64'd1 << FRAC);
		s = t;
		for (int n = 1; n <= SIN_TERMS; n++) begin
			if (odd) begin
				t = ((t * x2 + HALF_Q) >> FRAC) / SIN_DIV_ODD[n];
			end else begin
				t = ((t * x2 + HALF_Q) >> FRAC) / SIN_DIV_EVEN[n];
			end
			if ((n & 1) != 0) begin
				s = s - t;
			end else begin
				s = s + t;
			end
		end
		return s;
	endfunction

	function automatic rom_word_t sin_entry(int d);
		u64_t x;
		if (d <= 45) begin
			x = (u64_t'(d) * PI_Q32 + 64'd360) / 720;
			return rom_word_t'(series(x, 1'b1));
		end
		x = (u64_t'(90 - d) * PI_Q32 + 64'd360) / 720;
		return rom_word_t'(series(x, 1'b0));
	endfunction

	function automatic sin_rom_t sin_rom_build();
		sin_rom_t r;
		for (int d = 0; d <= 90; d++) begin
			r[d] = sin_entry(d);
		end
		return r;
	endfunction

	function automatic rom_word_t atan_entry(int i);
		u64_t s;
		u64_t t;
		s = 64'd0;
		if (i == 0) begin
			return rom_word_t'((PI_Q32 + 64'd8) >> 4);
		end
		for (int n = 0; n < ATAN_TERMS; n++) begin
			if (i * (2 * n + 1) <= 60) begin
				t = (64'd1 << (60 - i * (2 * n + 1))) / ATAN_DIV[n];
				if ((n & 1) != 0) begin
					s = s - t;
				end else begin
					s = s + t;
				end
			end
		end
		return rom_word_t'((s + HALF_Q) >> FRAC);
	endfunction

	function automatic atan_rom_t atan_rom_build();
		atan_rom_t r;
		for (int i = 0; i < ATAN_ROM_SIZE; i++) begin
			r[i] = atan_entry(i);
		end
		return r;
	endfunction

	localparam sin_rom_t SIN_ROM = sin_rom_build();
	localparam atan_rom_t ATAN_ROM = atan_rom_build();

endpackage

// ===== hdl/aahc_trig.sv =====
// Table lookup and product stages: sines and cosines, then the spherical products.
// Produces the altitude sine and both azimuth operands. Depends on aahc_pkg.
module aahc_trig (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [6:0]          lat,
	input  logic signed [7:0]   dec,
	input  logic [8:0]          lha,
	output logic                out_v,
	output aahc_pkg::side_t     side
);

	typedef struct packed {
		aahc_pkg::q_t sn;
		aahc_pkg::q_t cs;
	} sc_t;

	function automatic aahc_pkg::q_t rom(logic [8:0] idx);
		return aahc_pkg::q_t'(aahc_pkg::SIN_ROM[idx[6:0]]);
	endfunction

	function automatic sc_t lookup(logic [8:0] d);
		sc_t r;
		if (d <= 9'd90) begin
			r.sn = rom(d);
			r.cs = rom(9'd90 - d);
		end else if (d <= 9'd180) begin
			r.sn = rom(9'd180 - d);
			r.cs = -rom(d - 9'd90);
		end else if (d <= 9'd270) begin
			r.sn = -rom(d - 9'd180);
			r.cs = -rom(9'd270 - d);
		end else begin
			r.sn = -rom(9'd360 - d);
			r.cs = rom(d - 9'd270);
		end
		return r;
	endfunction

	function automatic aahc_pkg::q_t mulq(aahc_pkg::q_t a, aahc_pkg::q_t b);
		logic signed [2*aahc_pkg::QW-1:0] p;
		p = a * b;
		p = p + (2*aahc_pkg::QW)'(aahc_pkg::HALF_Q);
		return aahc_pkg::QW'(p >>> aahc_pkg::FRAC);
	endfunction

	logic [8:0] lat_n;
	logic [8:0] dec_n;
	logic [8:0] lha_n;
	sc_t        lat_sc;
	sc_t        dec_sc;
	sc_t        lha_sc;
	aahc_pkg::q_t sum;

	logic v_s1, v_s2, v_s3, v_s4;
	sc_t  lat_s1, dec_s1, lha_s1;
	aahc_pkg::q_t p1_s2, p2_s2, p3_s2, p4_s2, ay_s2, clha_s2;
	aahc_pkg::q_t p1_s3, q1_s3, p4_s3, q2_s3, ay_s3;
	aahc_pkg::side_t side_s4;

	always_comb begin
		lat_n = {2'b00, lat};
		dec_n = dec[7] ? (9'(dec) + 9'd360) : 9'(dec);
		lha_n = (lha >= 9'd360) ? (lha - 9'd360) : lha;
		lat_sc = lookup(lat_n);
		dec_sc = lookup(dec_n);
		lha_sc = lookup(lha_n);
		sum = p1_s3 + q1_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_s1 <= lat_sc;
			dec_s1 <= dec_sc;
			lha_s1 <= lha_sc;

			p1_s2   <= mulq(lat_s1.sn, dec_s1.sn);
			p2_s2   <= mulq(lat_s1.cs, dec_s1.cs);
			p3_s2   <= mulq(lat_s1.sn, dec_s1.cs);
			p4_s2   <= mulq(lat_s1.cs, dec_s1.sn);
			ay_s2   <= mulq(dec_s1.cs, lha_s1.sn);
			clha_s2 <= lha_s1.cs;

			p1_s3 <= p1_s2;
			q1_s3 <= mulq(p2_s2, clha_s2);
			p4_s3 <= p4_s2;
			q2_s3 <= mulq(p3_s2, clha_s2);
			ay_s3 <= ay_s2;

			if (sum > aahc_pkg::ONE_Q) begin
				side_s4.t <= aahc_pkg::ONE_Q;
			end else if (sum < -aahc_pkg::ONE_Q) begin
				side_s4.t <= -aahc_pkg::ONE_Q;
			end else begin
				side_s4.t <= sum;
			end
			side_s4.ax <= p4_s3 - q2_s3;
			side_s4.ay <= ay_s3;
		end
	end

	assign out_v = v_s4;
	assign side  = side_s4;

endmodule

// ===== hdl/aahc_isqrt.sv =====
// Pipelined integer square root of one minus the squared altitude sine, one bit a stage.
// Carries the azimuth operands alongside. Depends on aahc_pkg.
module aahc_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  aahc_pkg::side_t side_in,
	output logic            out_v,
	output aahc_pkg::side_t side_out,
	output logic [30:0]     root
);

	localparam int RW = 2 * aahc_pkg::FRAC + 2;
	localparam int STEPS = aahc_pkg::FRAC + 1;

	logic signed [2*aahc_pkg::QW-1:0] sq;
	logic [RW-1:0] rem_s [0:STEPS];
	logic [RW-1:0] res_s [0:STEPS];
	logic          v_s   [0:STEPS];
	aahc_pkg::side_t side_s [0:STEPS];

	assign sq = side_in.t * side_in.t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= (RW'(1) << (2 * aahc_pkg::FRAC)) - RW'(sq);
			res_s[0]  <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * aahc_pkg::FRAC - 2 * k);
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = res_s[k] + BIT;
			ge    = rem_s[k] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (ge) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign out_v    = v_s[STEPS];
	assign side_out = side_s[STEPS];
	assign root     = res_s[STEPS][30:0];

endmodule

// ===== hdl/aahc_cordic.sv =====
// Two-lane vectoring CORDIC: altitude lane and azimuth lane advance in lockstep.
// A half-turn pre-rotation handles a negative x. Depends on aahc_pkg.
module aahc_cordic #(
	parameter int STAGES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_v,
	input  aahc_pkg::q_t y_alt,
	input  aahc_pkg::q_t x_alt,
	input  aahc_pkg::q_t y_az,
	input  aahc_pkg::q_t x_az,
	input  logic         zero_in,
	output logic         out_v,
	output aahc_pkg::q_t z_alt,
	output aahc_pkg::q_t z_az,
	output logic         zero_out
);

	aahc_pkg::q_t x_s [0:STAGES][0:1];
	aahc_pkg::q_t y_s [0:STAGES][0:1];
	aahc_pkg::q_t z_s [0:STAGES][0:1];
	logic         v_s [0:STAGES];
	logic         zf_s [0:STAGES];
	aahc_pkg::q_t xin [0:1];
	aahc_pkg::q_t yin [0:1];

	assign xin[0] = x_alt;
	assign yin[0] = y_alt;
	assign xin[1] = x_az;
	assign yin[1] = y_az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= zero_in;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_pre
		always_ff @(posedge clk) begin
			if (en) begin
				if (xin[l] < 0) begin
					z_s[0][l] <= (yin[l] >= 0) ? aahc_pkg::PI_Q30 : -aahc_pkg::PI_Q30;
					x_s[0][l] <= -xin[l];
					y_s[0][l] <= -yin[l];
				end else begin
					z_s[0][l] <= '0;
					x_s[0][l] <= xin[l];
					y_s[0][l] <= yin[l];
				end
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam aahc_pkg::q_t ANG = aahc_pkg::q_t'(aahc_pkg::ATAN_ROM[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[i][l] >= 0) begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + ANG;
					end else begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - ANG;
					end
				end
			end
		end
	end

	assign out_v    = v_s[STAGES];
	assign z_alt    = z_s[STAGES][0];
	assign z_az     = z_s[STAGES][1];
	assign zero_out = zf_s[STAGES];

endmodule

// ===== hdl/aahc_scale.sv =====
// Angle scaler: radians in Q30 times FACTOR over pi, rounded half up, saturated.
// Division by the constant 2*pi uses a reciprocal multiply and one correction step.
// Depends on aahc_pkg.
module aahc_scale #(
	parameter int FACTOR = 108000,
	parameter int LIM = 54000,
	parameter int OW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  aahc_pkg::q_t         z,
	output logic                 out_v,
	output logic signed [OW-1:0] val
);

	localparam int QB = aahc_pkg::QB;
	localparam int PW = aahc_pkg::QW + 24;
	localparam int NW = QB + 36;
	localparam int NL = 20;
	localparam int NH = NW - NL;
	localparam int RW = 24;
	localparam int RSH = 36;
	localparam logic signed [PW-1:0] MULT = PW'(8 * FACTOR);
	localparam logic [NW-1:0] DIV = NW'(aahc_pkg::PI_Q32 << 1);
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << (NL + RSH)) / (aahc_pkg::PI_Q32 << 1));
	localparam logic signed [PW-1:0] OFS =
		PW'(aahc_pkg::PI_Q32) + (PW'(aahc_pkg::PI_Q32 << 1) << (QB - 1));
	localparam logic signed [QB:0] KOFS = (QB+1)'(1) << (QB - 1);
	localparam logic signed [QB:0] LIMV = (QB+1)'(LIM);

	logic signed [PW-1:0] prod_s1;
	logic [NW-1:0]        num_s2;
	logic [NW-1:0]        num_s3;
	logic [QB-1:0]        qa_s3;
	logic [QB-1:0]        qa_s4;
	logic [NW-1:0]        rem_s4;
	logic [QB:0]          q_s5;
	logic [NH+RW-1:0]     qp;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [QB:0]   qs;
	logic signed [OW-1:0] val_q;
	logic                 val_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			val_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_v;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			val_v_q <= v_s5;
		end
	end

	assign qp = num_s2[NW-1:NL] * RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(z) * MULT;
			num_s2  <= NW'(prod_s1 + OFS);
			num_s3  <= num_s2;
			qa_s3   <= qp[RSH+QB-1:RSH];
			rem_s4  <= num_s3 - (NW'(qa_s3) * DIV);
			qa_s4   <= qa_s3;
			if (rem_s4 >= DIV) begin
				q_s5 <= (QB+1)'(qa_s4) + (QB+1)'(1);
			end else begin
				q_s5 <= (QB+1)'(qa_s4);
			end
		end
	end

	assign qs = $signed(q_s5) - KOFS;

	always_ff @(posedge clk) begin
		if (en) begin
			if (qs > LIMV) begin
				val_q <= OW'(LIMV);
			end else if (qs < -LIMV) begin
				val_q <= OW'(-LIMV);
			end else begin
				val_q <= OW'(qs);
			end
		end
	end

	assign out_v = val_v_q;
	assign val   = val_q;

endmodule

// ===== hdl/altitude_azimuth_from_hour_angle_unit.sv =====
// Altitude and azimuth from latitude, declination and hour angle; instantiates the
// aahc_trig, aahc_isqrt, aahc_cordic and aahc_scale stages. Depends on aahc_pkg.
// The path runs through the 32 root stages, the CORDIC stages and the 6 scaling stages in series.
// Throughput: one transaction per cycle while the output skid register is empty; a full
// skid register drops s_tready and stalls the whole pipeline until it drains.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module altitude_azimuth_from_hour_angle_unit #(
	parameter int CORDIC_STAGES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // latitude_deg[6:0], declination_deg[14:7], hour_angle_deg[23:15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // altitude_tenth_arcmin[16:0], azimuth_tenth_deg[28:17], zero
);

	logic            en;
	logic            trig_v;
	aahc_pkg::side_t trig_side;
	logic            sq_v;
	aahc_pkg::side_t sq_side;
	logic [30:0]     root;
	logic            cor_v;
	aahc_pkg::q_t    z_alt;
	aahc_pkg::q_t    z_az;
	aahc_pkg::q_t    z_az_m;
	logic            zero_flag;
	logic            alt_v;
	logic            az_v;
	logic signed [16:0] alt_val;
	logic signed [11:0] az_val;
	logic            pv;

	logic               out_v_q;
	logic signed [16:0] out_alt_q;
	logic signed [11:0] out_az_q;
	logic               skid_v_q;
	logic signed [16:0] skid_alt_q;
	logic signed [11:0] skid_az_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	aahc_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (s_tvalid),
		.lat    (s_tdata[6:0]),
		.dec    (s_tdata[14:7]),
		.lha    (s_tdata[23:15]),
		.out_v  (trig_v),
		.side   (trig_side)
	);

	aahc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (trig_v),
		.side_in  (trig_side),
		.out_v    (sq_v),
		.side_out (sq_side),
		.root     (root)
	);

	aahc_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (sq_v),
		.y_alt    (sq_side.t),
		.x_alt    (aahc_pkg::q_t'(root)),
		.y_az     (sq_side.ay),
		.x_az     (sq_side.ax),
		.zero_in  ((sq_side.ax == '0) && (sq_side.ay == '0)),
		.out_v    (cor_v),
		.z_alt    (z_alt),
		.z_az     (z_az),
		.zero_out (zero_flag)
	);

	assign z_az_m = zero_flag ? '0 : z_az;

	aahc_scale #(
		.FACTOR (108000),
		.LIM    (54000),
		.OW     (17)
	) u_scale_alt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (cor_v),
		.z      (z_alt),
		.out_v  (alt_v),
		.val    (alt_val)
	);

	aahc_scale #(
		.FACTOR (1800),
		.LIM    (1800),
		.OW     (12)
	) u_scale_az (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (cor_v),
		.z      (z_az_m),
		.out_v  (az_v),
		.val    (az_val)
	);

	assign pv = alt_v && az_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pv;
			end
		end else if (pv) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_alt_q <= skid_alt_q;
				out_az_q  <= skid_az_q;
			end else begin
				out_alt_q <= alt_val;
				out_az_q  <= az_val;
			end
		end else if (pv && en) begin
			skid_alt_q <= alt_val;
			skid_az_q  <= az_val;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_az_q, out_alt_q};

	a_skid_implies_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full with empty output register");

	a_skid_fill : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready && pv))
		else $error("skid register filled without a stalled transaction");

	a_alt_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_alt_q <= 17'sd54000) && (out_alt_q >= -17'sd54000))
		else $error("altitude out of range");

	a_az_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_az_q <= 12'sd1800) && (out_az_q >= -12'sd1800))
		else $error("azimuth out of range");

endmodule
